/* sv/nearest_key_binary_search_assert.svh */
// ----------------------------------------------------------------------------
// nearest_key_binary_search assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef NEAREST_KEY_BINARY_SEARCH_ASSERT_SVH
`define NEAREST_KEY_BINARY_SEARCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define NKS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nks assertion failed");

// consequent must hold in the cycle after the antecedent
`define NKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nks assertion failed");

`endif

/* sv/nks_pkg.sv */
// ----------------------------------------------------------------------------
// nks_pkg
// shared widths, item kind codes and controller/datapath signal groups
// ----------------------------------------------------------------------------
package nks_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int INDEX_W     = 12;
  localparam int KEY_W       = 48;
  localparam int WORD_W      = 32;
  localparam int DIFF_W      = KEY_W + 1;

  // absolute key difference must be strictly below this to count as a hit
  localparam logic [DIFF_W-1:0] DIFF_LIMIT = DIFF_W'(64'd100000000000000);

  // item kind codes
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] tag;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic append;
    logic clear;
    logic load;
    logic start;
    logic probe;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic range_empty;
    logic probe_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/nks_in_if.sv */
// ----------------------------------------------------------------------------
// nks_in_if
// input word channel: valid/ready handshake with item kind and entry payload
// ----------------------------------------------------------------------------
interface nks_in_if
  import nks_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [KEY_W-1:0]  entry_key;
  logic [WORD_W-1:0] entry_value;
  logic [WORD_W-1:0] entry_tag;

  modport source (output valid, kind, entry_key, entry_value, entry_tag, input ready);
  modport sink   (input valid, kind, entry_key, entry_value, entry_tag, output ready);
endinterface

/* sv/nks_out_if.sv */
// ----------------------------------------------------------------------------
// nks_out_if
// result word channel: valid/ready handshake with the nearest entry fields
// ----------------------------------------------------------------------------
interface nks_out_if
  import nks_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] hit_index;
  logic [KEY_W-1:0]   hit_key;
  logic [WORD_W-1:0]  hit_value;
  logic [WORD_W-1:0]  hit_tag;

  modport source (output valid, found, hit_index, hit_key, hit_value, hit_tag, input ready);
  modport sink   (input valid, found, hit_index, hit_key, hit_value, hit_tag, output ready);
endinterface

/* sv/nks_ctrl.sv */
// ----------------------------------------------------------------------------
// nks_ctrl
// sequencer: accepts words, steps the search one probe per cycle, emits result
// ----------------------------------------------------------------------------
module nks_ctrl
  import nks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_kind,
  output logic       req_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_PROBE  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_kind)
            KIND_APPEND: cmd.append = 1'b1;
            KIND_CLEAR:  cmd.clear  = 1'b1;
            KIND_QUERY: begin
              cmd.load   = 1'b1;
              state_next = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = stat.range_empty ? ST_FINISH : ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.probe_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/nks_dp.sv */
// ----------------------------------------------------------------------------
// nks_dp
// entry table memory, search bounds, best-match tracking and result register
// ----------------------------------------------------------------------------
module nks_dp
  import nks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  input  logic [KEY_W-1:0]  entry_key,
  input  logic [WORD_W-1:0] entry_value,
  input  logic [WORD_W-1:0] entry_tag,
  output dp_stat_t          stat,
  nks_out_if.source         rsp
);

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_addr;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [IDX_W-1:0]   mid;
  logic [KEY_W-1:0]   target;
  logic [DIFF_W-1:0]  best_diff;
  logic               have;
  logic [IDX_W-1:0]   best_idx;
  logic [KEY_W-1:0]   best_key;
  logic [WORD_W-1:0]  best_value;
  logic [WORD_W-1:0]  best_tag;

  logic               out_valid;
  logic               out_found;
  logic [INDEX_W-1:0] out_index;
  logic [KEY_W-1:0]   out_key;
  logic [WORD_W-1:0]  out_value;
  logic [WORD_W-1:0]  out_tag;

  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  abs_diff;
  logic               key_lt;
  logic               key_gt;
  logic               key_eq;
  logic [CNT_W-1:0]   lo_n;
  logic [CNT_W-1:0]   hi_n;

  // midpoint of the half-open range [a, b), valid only when a < b
  function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b} - 1'b1;
    return s[IDX_W:1];
  endfunction

  // probe compare against the entry read last cycle
  always_comb begin
    diff     = {rd_data.key[KEY_W-1], rd_data.key} - {target[KEY_W-1], target};
    abs_diff = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    key_lt   = $signed(rd_data.key) < $signed(target);
    key_gt   = $signed(rd_data.key) > $signed(target);
    key_eq   = (rd_data.key == target);
    lo_n     = key_lt ? (CNT_W'(mid) + 1'b1) : lo;
    hi_n     = key_gt ? CNT_W'(mid) : hi;
  end

  // next probe address
  assign rd_addr = cmd.start ? mid_of(lo, hi) : mid_of(lo_n, hi_n);

  assign stat.range_empty = !(lo < hi);
  assign stat.probe_last  = key_eq || !(lo_n < hi_n);
  assign stat.out_free    = !out_valid || rsp.ready;

  // table memory: append write, registered probe read
  always_ff @(posedge clk) begin
    if (cmd.append && (count < CNT_W'(TABLE_DEPTH))) begin
      mem[count[IDX_W-1:0]] <= '{key: entry_key, value: entry_value, tag: entry_tag};
    end
    rd_data <= mem[rd_addr];
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.append && (count < CNT_W'(TABLE_DEPTH))) begin
      count <= count + 1'b1;
    end
  end

  // search bounds and best match
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.load) begin
      have <= 1'b0;
    end else if (cmd.probe && (abs_diff < best_diff)) begin
      have <= 1'b1;
    end
    if (cmd.load) begin
      lo         <= '0;
      hi         <= count;
      target     <= entry_key;
      best_diff  <= DIFF_LIMIT;
      best_idx   <= '0;
      best_key   <= '0;
      best_value <= '0;
      best_tag   <= '0;
    end
    if (cmd.start || cmd.probe) begin
      mid <= rd_addr;
    end
    if (cmd.probe) begin
      lo <= lo_n;
      hi <= hi_n;
      if (abs_diff < best_diff) begin
        best_diff  <= abs_diff;
        best_idx   <= mid;
        best_key   <= rd_data.key;
        best_value <= rd_data.value;
        best_tag   <= rd_data.tag;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_found <= have;
      out_index <= INDEX_W'(best_idx);
      out_key   <= best_key;
      out_value <= best_value;
      out_tag   <= best_tag;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.found     = out_found;
  assign rsp.hit_index = out_index;
  assign rsp.hit_key   = out_key;
  assign rsp.hit_value = out_value;
  assign rsp.hit_tag   = out_tag;

endmodule

/* sv/nearest_key_binary_search.sv */
// ----------------------------------------------------------------------------
// nearest_key_binary_search: append, clear and nearest-key query over a table
// append and clear words are taken while idle; a query makes P probes, P from
// 0 to 13 at 4096 entries, one per cycle through the memory port
// reset empties the table and the result register; stored entries not cleared
// ----------------------------------------------------------------------------
module nearest_key_binary_search
  import nks_pkg::*;
(
  input logic       clk,
  input logic       rst,
  nks_in_if.sink    req,
  nks_out_if.source rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  nks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table and search datapath
  nks_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .entry_key   (req.entry_key),
    .entry_value (req.entry_value),
    .entry_tag   (req.entry_tag),
    .stat        (stat),
    .rsp         (rsp)
  );

  `include "nearest_key_binary_search_assert.svh"

  // a result word appears only when the sequencer emits one
  `NKS_ASSERT_SAME(a_rise_from_emit, $rose(rsp.valid), $past(cmd.emit))

  // an accepted query keeps the input side closed while it searches
  `NKS_ASSERT_NEXT(a_query_busy, req.valid && req.ready && (req.kind == KIND_QUERY), !req.ready)

  // a result is never loaded over one still waiting
  `NKS_ASSERT_SAME(a_emit_free, cmd.emit, !rsp.valid || rsp.ready)

endmodule
